FILE: rtl/robb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// robb_pkg
// shared types and constants for the ray versus oriented box slab test
// ----------------------------------------------------------------------------
package robb_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 40;
  localparam int EPS_WIDTH       = 16;
  localparam int CFG_IDX_WIDTH   = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_DIR_X     = 3'd3,
    REG_DIR_Y     = 3'd4,
    REG_DIR_Z     = 3'd5,
    REG_FAR_START = 3'd6,
    REG_EPS       = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL,
    ST_FCHK,
    ST_NUM,
    ST_DIV,
    ST_QSAT,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/robb_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// robb_divider
// radix-2 restoring divider on magnitudes, one quotient bit per cycle
// ----------------------------------------------------------------------------
module robb_divider #(
  parameter int NUM_WIDTH = 80,
  parameter int DEN_WIDTH = 40
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [NUM_WIDTH-1:0] num,
  input  wire logic [DEN_WIDTH-1:0] den,
  output logic                      done,
  output logic [NUM_WIDTH-1:0]      quo
);

  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] q_r, q_nxt;
  logic [DEN_WIDTH:0]   rem_r, rem_nxt;
  logic [DEN_WIDTH-1:0] den_r, den_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DEN_WIDTH:0]   trial;
  logic [DEN_WIDTH:0]   diff;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_WIDTH-1:0], q_r[NUM_WIDTH-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(NUM_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DEN_WIDTH]) begin
        rem_nxt = diff;
        q_nxt   = {q_r[NUM_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

FILE: rtl/ray_obb_slab_intersect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_obb_slab_intersect
// ray against oriented box, slab method, signed fixed point
//
// the ray (origin, direction), the initial far distance and the parallel
// threshold sit in registers written through the cfg_ channel (valid/ready),
// only while the block is idle. each in_ beat carries one slab of a box;
// a beat with last_slab closes the box and yields one out_ beat with hit and
// the near distance. in_stall is high while a slab is being worked on.
// after a beat is taken in_stall stays high until the slab is done; once
// the box has missed only the delta and out states run. otherwise one shared
// half-width multiplier forms the dot products in partial products, and,
// unless the ray is parallel to the slab, one bit-serial divider forms both
// plane distances in turn. the out_ beat shows up when the out state ends.
// the result waits in an output register while out_stall is high; the next
// in_ beat is taken only after it has left.
// reset clears the interval, loads the register reset values and idles.
// ----------------------------------------------------------------------------
module ray_obb_slab_intersect #(
  parameter int FRAC_BITS   = robb_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = robb_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [robb_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [VALUE_WIDTH-1:0]             cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_axis_x,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_axis_y,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_axis_z,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_center_x,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_center_y,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_center_z,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_slab_lo,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_slab_hi,
  input  wire logic                               in_last_slab,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_hit,
  output logic [VALUE_WIDTH-2:0]                  out_distance
);

  localparam int W   = VALUE_WIDTH;
  localparam int HW  = (W + 1) / 2;       // half magnitude width
  localparam int PW  = 2 * W;             // product width
  localparam int AW  = PW + 4;            // accumulator width
  localparam int NW  = 2 * W + 2;         // numerator magnitude width
  localparam int EW  = robb_pkg::EPS_WIDTH;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-2:0] FAR_RST = (W-1)'(64'd100000 << FRAC_BITS);
  localparam logic [W-1:0] DIRZ_RST = W'(64'd1 << FRAC_BITS);

  // configuration registers
  logic signed [W-1:0] org_r [3];
  logic signed [W-1:0] dir_r [3];
  logic [W-2:0]        far_r;
  logic [EW-1:0]       eps_r;

  // item registers
  logic signed [W-1:0] axis_r [3];
  logic signed [W-1:0] delta_r [3];
  logic signed [W-1:0] lo_r, hi_r;
  logic                last_r;

  // interval state
  logic signed [W-1:0] tn_r, tf_r;
  logic                missed_r;

  logic signed [W-1:0] e_r, f_r;
  logic signed [W-1:0] t1_r;

  robb_pkg::state_t st_r, st_nxt;
  logic [3:0]  step_r, step_nxt;   // multiply step: term*4 + partial
  logic        dot_r;              // 0: e, 1: f
  logic        bsel_r;             // 0: lo bound, 1: hi bound
  logic signed [AW-1:0] acc_r;     // product accumulator
  logic signed [AW-1:0] sum_r;     // dot sum
  logic                 pneg_r;

  logic          ovalid_r;
  logic          ohit_r;
  logic [W-2:0]  odist_r;

  // ---- configuration ----
  assign cfg_ready = (st_r == robb_pkg::ST_IDLE) && !ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0; org_r[1] <= '0; org_r[2] <= '0;
      dir_r[0] <= '0; dir_r[1] <= '0; dir_r[2] <= DIRZ_RST;
      far_r    <= FAR_RST;
      eps_r    <= EW'(66);
    end else if (cfg_valid && cfg_ready) begin
      unique case (robb_pkg::cfg_reg_t'(cfg_index))
        robb_pkg::REG_ORIGIN_X:  org_r[0] <= cfg_data;
        robb_pkg::REG_ORIGIN_Y:  org_r[1] <= cfg_data;
        robb_pkg::REG_ORIGIN_Z:  org_r[2] <= cfg_data;
        robb_pkg::REG_DIR_X:     dir_r[0] <= cfg_data;
        robb_pkg::REG_DIR_Y:     dir_r[1] <= cfg_data;
        robb_pkg::REG_DIR_Z:     dir_r[2] <= cfg_data;
        robb_pkg::REG_FAR_START: far_r    <= cfg_data[W-2:0];
        robb_pkg::REG_EPS:       eps_r    <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  // ---- shared multiplier: magnitude halves, one partial per cycle ----
  logic [1:0]           term;
  logic [1:0]           part;
  logic signed [W-1:0]  ma, mb;
  logic [W-1:0]         ua, ub;
  logic [HW-1:0]        pa, pb;
  logic [2*HW-1:0]      pp;
  logic signed [AW-1:0] pp_sh;
  logic                 mneg;

  assign term = step_r[3:2];
  assign part = step_r[1:0];

  always_comb begin
    ma = dot_r ? dir_r[term] : axis_r[term];
    mb = dot_r ? axis_r[term] : delta_r[term];
    ua = ma[W-1] ? W'(-ma) : ma;
    ub = mb[W-1] ? W'(-mb) : mb;
    pa = part[1] ? HW'(ua >> HW) : HW'(ua);
    pb = part[0] ? HW'(ub >> HW) : HW'(ub);
    mneg = ma[W-1] ^ mb[W-1];
  end

  assign pp = pa * pb;
  assign pp_sh = AW'(pp) << (HW * (32'(part[1]) + 32'(part[0])));

  // ---- divider ----
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [W-1:0]  div_den;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic signed [W+1:0] nsum;
  logic signed [NW:0]  nshift;
  logic          qneg_r;

  robb_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign nsum   = (W+2)'(e_r) + (bsel_r ? (W+2)'(hi_r) : (W+2)'(lo_r));
  assign nshift = (NW+1)'(nsum) <<< FRAC_BITS;
  assign div_num = nshift[NW] ? NW'(-nshift) : NW'(nshift);
  assign div_den = f_r[W-1] ? W'(-f_r) : W'(f_r);
  assign div_start = (st_r == robb_pkg::ST_NUM);

  // ---- saturation helpers ----
  function automatic logic signed [W-1:0] sat_acc(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] mx, mn;
    begin
      mx = AW'(VMAX);
      mn = AW'(VMIN);
      if (v > mx) sat_acc = VMAX;
      else if (v < mn) sat_acc = VMIN;
      else sat_acc = W'(v);
    end
  endfunction

  logic signed [NW:0]  qs;
  logic signed [W-1:0] qsat;
  logic [W-1:0]        fmag;
  logic signed [W+1:0] lchk, hchk;
  logic signed [W-1:0] tmin, tmax, tn_new, tf_new;

  assign qs   = qneg_r ? -(NW+1)'(div_quo) : (NW+1)'(div_quo);
  assign qsat = (qs > (NW+1)'(VMAX)) ? VMAX : (qs < (NW+1)'(VMIN)) ? VMIN : W'(qs);
  assign fmag = f_r[W-1] ? W'(-f_r) : W'(f_r);
  assign lchk = (W+2)'(lo_r) - (W+2)'(e_r);
  assign hchk = (W+2)'(hi_r) - (W+2)'(e_r);

  assign tmin   = (t1_r < qsat) ? t1_r : qsat;
  assign tmax   = (t1_r < qsat) ? qsat : t1_r;
  assign tn_new = (tmin > tn_r) ? tmin : tn_r;
  assign tf_new = (tmax < tf_r) ? tmax : tf_r;

  // ---- sequencer ----
  logic take_in;
  assign in_stall = (st_r != robb_pkg::ST_IDLE) || ovalid_r;
  assign take_in  = in_valid && !in_stall;

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    unique case (st_r)
      robb_pkg::ST_IDLE: if (take_in) st_nxt = robb_pkg::ST_DELTA;
      robb_pkg::ST_DELTA: begin
        step_nxt = '0;
        st_nxt   = missed_r ? robb_pkg::ST_OUT : robb_pkg::ST_MUL;
      end
      robb_pkg::ST_MUL: begin
        if (step_r[1:0] == 2'd3) begin
          if (step_r[3:2] == 2'd2) begin
            step_nxt = '0;
            if (dot_r) st_nxt = robb_pkg::ST_FCHK;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      robb_pkg::ST_FCHK: begin
        if (fmag > W'(eps_r)) st_nxt = robb_pkg::ST_NUM;
        else st_nxt = robb_pkg::ST_OUT;
      end
      robb_pkg::ST_NUM:  st_nxt = robb_pkg::ST_DIV;
      robb_pkg::ST_DIV:  if (div_done) st_nxt = robb_pkg::ST_QSAT;
      robb_pkg::ST_QSAT: st_nxt = bsel_r ? robb_pkg::ST_UPD : robb_pkg::ST_NUM;
      robb_pkg::ST_UPD:  st_nxt = robb_pkg::ST_OUT;
      robb_pkg::ST_OUT:  st_nxt = robb_pkg::ST_IDLE;
      default:           st_nxt = robb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= robb_pkg::ST_IDLE;
      step_r   <= '0;
      tn_r     <= '0;
      tf_r     <= W'(FAR_RST);
      missed_r <= 1'b0;
      ovalid_r <= 1'b0;
      dot_r    <= 1'b0;
      bsel_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (cfg_valid && cfg_ready &&
          robb_pkg::cfg_reg_t'(cfg_index) == robb_pkg::REG_FAR_START)
        tf_r <= {1'b0, cfg_data[W-2:0]};
      unique case (st_r)
        robb_pkg::ST_IDLE: begin
          dot_r  <= 1'b0;
          bsel_r <= 1'b0;
        end
        robb_pkg::ST_MUL: begin
          if (step_r[1:0] == 2'd3 && step_r[3:2] == 2'd2) dot_r <= 1'b1;
        end
        robb_pkg::ST_FCHK: begin
          if (!(fmag > W'(eps_r)) && (!lchk[W+1] && lchk != '0 || hchk[W+1]))
            missed_r <= 1'b1;
        end
        robb_pkg::ST_QSAT: bsel_r <= 1'b1;
        robb_pkg::ST_UPD: begin
          tn_r <= tn_new;
          tf_r <= tf_new;
          if (tn_new > tf_new) missed_r <= 1'b1;
        end
        robb_pkg::ST_OUT: begin
          if (last_r) begin
            ovalid_r <= 1'b1;
            tn_r     <= '0;
            tf_r     <= {1'b0, far_r};
            missed_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- datapath registers ----
  logic signed [AW-1:0] prod_s;
  logic signed [AW-1:0] term_sh;
  assign prod_s  = pneg_r ? -acc_r : acc_r;
  assign term_sh = prod_s >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (take_in) begin
      axis_r[0] <= in_axis_x; axis_r[1] <= in_axis_y; axis_r[2] <= in_axis_z;
      delta_r[0] <= in_center_x; delta_r[1] <= in_center_y;
      delta_r[2] <= in_center_z;
      lo_r   <= in_slab_lo;
      hi_r   <= in_slab_hi;
      last_r <= in_last_slab;
    end
    if (st_r == robb_pkg::ST_DELTA) begin
      for (int i = 0; i < 3; i++)
        delta_r[i] <= sat_acc(AW'(delta_r[i]) - AW'(org_r[i]));
      sum_r <= '0;
      acc_r <= '0;
    end
    if (st_r == robb_pkg::ST_MUL) begin
      if (part == 2'd0) begin
        acc_r  <= pp_sh;
        pneg_r <= mneg;
        if (term != 2'd0) sum_r <= sum_r + term_sh;
      end else begin
        acc_r <= acc_r + pp_sh;
      end
      if (step_r == 4'd11) begin
        if (dot_r) f_r <= sat_acc(sum_r + ((mneg ? -(acc_r + pp_sh) : (acc_r + pp_sh))
                                           >>> FRAC_BITS));
        else begin
          e_r   <= sat_acc(sum_r + ((mneg ? -(acc_r + pp_sh) : (acc_r + pp_sh))
                                    >>> FRAC_BITS));
          sum_r <= '0;
        end
      end
    end
    if (st_r == robb_pkg::ST_NUM) qneg_r <= nshift[NW] ^ f_r[W-1];
    if (st_r == robb_pkg::ST_QSAT && !bsel_r) t1_r <= qsat;
    if (st_r == robb_pkg::ST_OUT && last_r) begin
      ohit_r  <= !missed_r;
      odist_r <= missed_r ? '0 : tn_r[W-2:0];
    end
  end

  assign out_valid    = ovalid_r;
  assign out_hit      = ohit_r;
  assign out_distance = odist_r;

endmodule
`default_nettype wire
